FILE: src/bbs_pkg.sv
// Shared types, constants and the control store for the bouncing ball stepper.
// Used by bbs_datapath and bouncing_ball_step; depends on nothing else.
`timescale 1ns / 1ps

package bbs_pkg;

    // ball geometry and number ranges
    localparam int          BALL_RADIUS = 10;
    localparam logic [19:0] R_POS       = 20'(BALL_RADIUS * 256);
    localparam logic [11:0] R_PIX       = 12'(BALL_RADIUS);
    localparam logic [19:0] POS_MAX     = 20'hFFFFF;
    localparam logic [23:0] VEL_MAX     = 24'h7FFFFF;
    localparam logic [23:0] VEL_MIN     = 24'h800000;

    // register reset values
    localparam logic [23:0] GRAVITY_RST     = 24'd250880;
    localparam logic [15:0] FRICTION_RST    = 16'd26214;
    localparam logic [15:0] RESTITUTION_RST = 16'd55706;
    localparam logic [11:0] WIDTH_RST       = 12'd800;
    localparam logic [11:0] HEIGHT_RST      = 12'd600;
    localparam logic [19:0] START_X_RST     = 20'd102400;
    localparam logic [19:0] START_Y_RST     = 20'd76800;
    localparam logic [16:0] START_VX_RST    = 17'd0;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_GRAVITY     = 3'd0,
        REG_FRICTION    = 3'd1,
        REG_RESTITUTION = 3'd2,
        REG_WIDTH       = 3'd3,
        REG_HEIGHT      = 3'd4,
        REG_START_X     = 3'd5,
        REG_START_Y     = 3'd6,
        REG_START_VX    = 3'd7
    } t_reg_idx;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [15:0] dt;
    } t_in_item;

    typedef struct packed {
        logic [19:0]        x_pos;
        logic [19:0]        y_pos;
        logic signed [23:0] x_vel;
        logic signed [23:0] y_vel;
        logic               hit_floor;
        logic               hit_ceiling;
        logic               hit_left;
        logic               hit_right;
    } t_out_item;

    typedef struct packed {
        logic [23:0]        gravity;
        logic [15:0]        friction_coef;
        logic [15:0]        restitution;
        logic [11:0]        frame_w;
        logic [11:0]        frame_h;
        logic [19:0]        start_x;
        logic [19:0]        start_y;
        logic signed [16:0] start_vx;
    } t_cfg;

    // sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef logic [3:0] t_upc;

    // program entry points and jump targets
    localparam t_upc UPC_TICK    = 4'd0;
    localparam t_upc UPC_XWALL   = 4'd8;
    localparam t_upc UPC_GRAV    = 4'd10;
    localparam t_upc UPC_DONE    = 4'd11;
    localparam t_upc UPC_RESTART = 4'd12;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VX_DT,
        MUL_VY_DT,
        MUL_G_DT,
        MUL_NVY_R,
        MUL_NVX_R,
        MUL_THI_F,
        MUL_TLO_F
    } t_mul_sel;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_MOVE,
        POS_CLAMP,
        POS_LOAD
    } t_pos_op;

    typedef enum logic [1:0] {
        VEL_HOLD,
        VEL_BOUNCE,
        VEL_ADJUST,
        VEL_LOAD
    } t_vel_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_NO_Y_HIT,
        JMP_NO_FLOOR,
        JMP_NO_X_HIT
    } t_jmp;

    // one control word
    typedef struct packed {
        t_mul_sel mul_sel;
        t_pos_op  px_op;
        t_pos_op  py_op;
        t_vel_op  vx_op;
        t_vel_op  vy_op;
        t_acc_op  acc_op;
        logic     t_we;
        logic     clr_flags;
        logic     test_y;
        logic     test_x;
        t_jmp     jmp;
        t_upc     target;
        logic     done;
    } t_ucode;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic y_hit;
        logic floor_hit;
        logic x_hit;
    } t_dp_status;

    localparam t_ucode CW_NOP = '{
        mul_sel:   MUL_NONE,
        px_op:     POS_HOLD,
        py_op:     POS_HOLD,
        vx_op:     VEL_HOLD,
        vy_op:     VEL_HOLD,
        acc_op:    ACC_HOLD,
        t_we:      1'b0,
        clr_flags: 1'b0,
        test_y:    1'b0,
        test_x:    1'b0,
        jmp:       JMP_NONE,
        target:    UPC_TICK,
        done:      1'b0
    };

    // control store
    function automatic t_ucode ucode_rom(input t_upc addr);
        t_ucode cw;
        cw = CW_NOP;
        case (addr)
            // velocity times dt for x, clear flags
            4'd0: begin
                cw.mul_sel   = MUL_VX_DT;
                cw.clr_flags = 1'b1;
            end
            4'd1: begin
                cw.px_op   = POS_MOVE;
                cw.mul_sel = MUL_VY_DT;
            end
            4'd2: begin
                cw.py_op   = POS_MOVE;
                cw.mul_sel = MUL_G_DT;
            end
            // keep gravity*dt, test floor and ceiling
            4'd3: begin
                cw.t_we    = 1'b1;
                cw.test_y  = 1'b1;
                cw.mul_sel = MUL_NVY_R;
                cw.jmp     = JMP_NO_Y_HIT;
                cw.target  = UPC_XWALL;
            end
            4'd4: begin
                cw.vy_op   = VEL_BOUNCE;
                cw.py_op   = POS_CLAMP;
                cw.mul_sel = MUL_THI_F;
                cw.jmp     = JMP_NO_FLOOR;
                cw.target  = UPC_XWALL;
            end
            // floor friction in two partial products
            4'd5: begin
                cw.acc_op  = ACC_LOAD;
                cw.mul_sel = MUL_TLO_F;
            end
            4'd6: cw.acc_op = ACC_ADD;
            4'd7: cw.vx_op  = VEL_ADJUST;
            // side walls
            4'd8: begin
                cw.test_x  = 1'b1;
                cw.mul_sel = MUL_NVX_R;
                cw.jmp     = JMP_NO_X_HIT;
                cw.target  = UPC_GRAV;
            end
            4'd9: begin
                cw.vx_op = VEL_BOUNCE;
                cw.px_op = POS_CLAMP;
            end
            4'd10: cw.vy_op = VEL_ADJUST;
            4'd11: cw.done  = 1'b1;
            4'd12: begin
                cw.px_op     = POS_LOAD;
                cw.py_op     = POS_LOAD;
                cw.vx_op     = VEL_LOAD;
                cw.vy_op     = VEL_LOAD;
                cw.clr_flags = 1'b1;
                cw.jmp       = JMP_ALWAYS;
                cw.target    = UPC_DONE;
            end
            default: begin
                cw.jmp    = JMP_ALWAYS;
                cw.target = UPC_DONE;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: src/bbs_datapath.sv
// Datapath of the bouncing ball stepper: ball state, one shared multiplier, bounce tests.
// Driven by control words from the sequencer; depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_datapath import bbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ucode      i_cw,
    input  t_cfg        i_cfg,
    input  logic [15:0] i_dt,
    output t_dp_status  o_status,
    output t_out_item   o_result
);

    logic [19:0]        r_px, n_px;
    logic [19:0]        r_py, n_py;
    logic signed [23:0] r_vx, n_vx;
    logic signed [23:0] r_vy, n_vy;
    logic signed [40:0] r_prod;
    logic [39:0]        r_t;
    logic [40:0]        r_acc, n_acc;
    logic               r_hf, r_hc, r_hl, r_hr;

    logic signed [24:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [41:0] mul_full;
    logic signed [24:0] vx_ext, vy_ext;
    logic signed [25:0] px_sum, py_sum;
    logic signed [25:0] vx_fric, vy_grav;
    logic [20:0]        px_far_edge, py_far_edge;
    logic               floor_c, ceil_c, left_c, right_c;

    function automatic logic [19:0] sat_pos(input logic signed [25:0] v);
        logic [19:0] r;
        if (v[25])
            r = '0;
        else if (v[24:20] != 5'd0)
            r = POS_MAX;
        else
            r = v[19:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat_vel26(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (!v[25] && (v[24:23] != 2'b00))
            r = VEL_MAX;
        else if (v[25] && (v[24:23] != 2'b11))
            r = VEL_MIN;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat_vel25(input logic signed [24:0] v);
        logic signed [23:0] r;
        if (v[24] != v[23])
            r = v[24] ? VEL_MIN : VEL_MAX;
        else
            r = v[23:0];
        return r;
    endfunction

    // far border target, zero when the window is smaller than the ball radius
    function automatic logic [19:0] border_far(input logic [11:0] size);
        logic [19:0] r;
        if (size >= R_PIX)
            r = {size - R_PIX, 8'd0};
        else
            r = '0;
        return r;
    endfunction

    assign vx_ext = {r_vx[23], r_vx};
    assign vy_ext = {r_vy[23], r_vy};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cw.mul_sel)
            MUL_VX_DT: begin mul_a = vx_ext;                 mul_b = i_dt; end
            MUL_VY_DT: begin mul_a = vy_ext;                 mul_b = i_dt; end
            MUL_G_DT:  begin mul_a = {1'b0, i_cfg.gravity};  mul_b = i_dt; end
            MUL_NVY_R: begin mul_a = -vy_ext;                mul_b = i_cfg.restitution; end
            MUL_NVX_R: begin mul_a = -vx_ext;                mul_b = i_cfg.restitution; end
            MUL_THI_F: begin mul_a = {1'b0, r_t[39:16]};     mul_b = i_cfg.friction_coef; end
            MUL_TLO_F: begin mul_a = {9'd0, r_t[15:0]};      mul_b = i_cfg.friction_coef; end
            default:   begin mul_a = '0;                     mul_b = '0; end
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});

    // position moves, product scaled back by 16 bits
    assign px_sum = $signed({6'd0, r_px}) + $signed({r_prod[40], r_prod[40:16]});
    assign py_sum = $signed({6'd0, r_py}) + $signed({r_prod[40], r_prod[40:16]});

    // border tests on the moved position
    assign py_far_edge = {1'b0, r_py} + {1'b0, R_POS};
    assign px_far_edge = {1'b0, r_px} + {1'b0, R_POS};
    assign floor_c = (py_far_edge >= {1'b0, i_cfg.frame_h, 8'd0}) && !r_vy[23];
    assign ceil_c  = (r_py <= R_POS) && r_vy[23];
    assign left_c  = (r_px <= R_POS) && r_vx[23];
    assign right_c = (px_far_edge >= {1'b0, i_cfg.frame_w, 8'd0}) && !r_vx[23];

    // friction pull toward zero, and gravity added to vertical speed
    always_comb begin
        if (r_vx[23])
            vx_fric = $signed({vx_ext[24], vx_ext}) + $signed({1'b0, r_acc[40:16]});
        else if (r_vx != 24'sd0)
            vx_fric = $signed({vx_ext[24], vx_ext}) - $signed({1'b0, r_acc[40:16]});
        else
            vx_fric = $signed({vx_ext[24], vx_ext});
    end

    assign vy_grav = $signed({vy_ext[24], vy_ext}) + $signed({2'b00, r_t[39:16]});

    // next values of the ball state
    always_comb begin
        n_px = r_px;
        case (i_cw.px_op)
            POS_MOVE:  n_px = sat_pos(px_sum);
            POS_CLAMP: n_px = r_hl ? R_POS : border_far(i_cfg.frame_w);
            POS_LOAD:  n_px = i_cfg.start_x;
            default:   n_px = r_px;
        endcase

        n_py = r_py;
        case (i_cw.py_op)
            POS_MOVE:  n_py = sat_pos(py_sum);
            POS_CLAMP: n_py = r_hf ? border_far(i_cfg.frame_h) : R_POS;
            POS_LOAD:  n_py = i_cfg.start_y;
            default:   n_py = r_py;
        endcase

        n_vx = r_vx;
        case (i_cw.vx_op)
            VEL_BOUNCE: n_vx = sat_vel25(r_prod[40:16]);
            VEL_ADJUST: n_vx = sat_vel26(vx_fric);
            VEL_LOAD:   n_vx = 24'(i_cfg.start_vx);
            default:    n_vx = r_vx;
        endcase

        n_vy = r_vy;
        case (i_cw.vy_op)
            VEL_BOUNCE: n_vy = sat_vel25(r_prod[40:16]);
            VEL_ADJUST: n_vy = sat_vel26(vy_grav);
            VEL_LOAD:   n_vy = '0;
            default:    n_vy = r_vy;
        endcase

        n_acc = r_acc;
        case (i_cw.acc_op)
            ACC_LOAD: n_acc = r_prod[40:0];
            ACC_ADD:  n_acc = r_acc + {25'd0, r_prod[31:16]};
            default:  n_acc = r_acc;
        endcase
    end

    // ball state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_vx <= '0;
            r_vy <= '0;
        end else begin
            r_px <= n_px;
            r_py <= n_py;
            r_vx <= n_vx;
            r_vy <= n_vy;
        end
    end

    // product, gravity*dt and friction accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[40:0];
        r_acc  <= n_acc;
        if (i_cw.t_we) begin
            r_t <= r_prod[39:0];
        end
    end

    // bounce flags
    always_ff @(posedge i_clk) begin
        if (i_cw.clr_flags) begin
            r_hf <= 1'b0;
            r_hc <= 1'b0;
            r_hl <= 1'b0;
            r_hr <= 1'b0;
        end else begin
            if (i_cw.test_y) begin
                r_hf <= floor_c;
                r_hc <= !floor_c && ceil_c;
            end
            if (i_cw.test_x) begin
                r_hl <= left_c;
                r_hr <= !left_c && right_c;
            end
        end
    end

    assign o_status.y_hit     = floor_c || ceil_c;
    assign o_status.floor_hit = r_hf;
    assign o_status.x_hit     = left_c || right_c;

    assign o_result.x_pos       = r_px;
    assign o_result.y_pos       = r_py;
    assign o_result.x_vel       = r_vx;
    assign o_result.y_vel       = r_vy;
    assign o_result.hit_floor   = r_hf;
    assign o_result.hit_ceiling = r_hc;
    assign o_result.hit_left    = r_hl;
    assign o_result.hit_right   = r_hr;

endmodule

FILE: src/bouncing_ball_step.sv
// Bouncing ball stepper: each tick or restart item is run to a result by a microcode sequencer.
// One item at a time; a tick runs its control words through the shared 25x17 multiplier
// and a result step, bounces taking the longer paths.
// The result sits in an output register, so the next item is taken while it waits.
// Synchronous active-low reset zeroes the ball state and loads register defaults.
// Top level: register port, microcode sequencer, output stage; uses bbs_pkg, bbs_datapath.
`timescale 1ns / 1ps

module bouncing_ball_step import bbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_seq_state r_state, n_state;
    t_upc       r_upc, n_upc;
    logic [15:0] r_dt;
    logic       r_out_valid;
    t_out_item  r_out_item;

    t_ucode     rom_cw;
    t_ucode     dp_cw;
    t_dp_status dp_status;
    t_out_item  dp_result;
    logic       in_xfer;
    logic       can_out;
    logic       out_load;
    logic       jump_taken;
    logic       cfg_write;
    t_reg_idx   reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity       <= GRAVITY_RST;
            r_cfg.friction_coef <= FRICTION_RST;
            r_cfg.restitution   <= RESTITUTION_RST;
            r_cfg.frame_w       <= WIDTH_RST;
            r_cfg.frame_h       <= HEIGHT_RST;
            r_cfg.start_x       <= START_X_RST;
            r_cfg.start_y       <= START_Y_RST;
            r_cfg.start_vx      <= START_VX_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_GRAVITY:     r_cfg.gravity       <= pwdata[23:0];
                REG_FRICTION:    r_cfg.friction_coef <= pwdata[15:0];
                REG_RESTITUTION: r_cfg.restitution   <= pwdata[15:0];
                REG_WIDTH:       r_cfg.frame_w       <= pwdata[11:0];
                REG_HEIGHT:      r_cfg.frame_h       <= pwdata[11:0];
                REG_START_X:     r_cfg.start_x       <= pwdata[19:0];
                REG_START_Y:     r_cfg.start_y       <= pwdata[19:0];
                REG_START_VX:    r_cfg.start_vx      <= pwdata[16:0];
                default:         r_cfg.gravity       <= r_cfg.gravity;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_GRAVITY:     prdata = {8'd0, r_cfg.gravity};
            REG_FRICTION:    prdata = {16'd0, r_cfg.friction_coef};
            REG_RESTITUTION: prdata = {16'd0, r_cfg.restitution};
            REG_WIDTH:       prdata = {20'd0, r_cfg.frame_w};
            REG_HEIGHT:      prdata = {20'd0, r_cfg.frame_h};
            REG_START_X:     prdata = {12'd0, r_cfg.start_x};
            REG_START_Y:     prdata = {12'd0, r_cfg.start_y};
            REG_START_VX:    prdata = 32'(r_cfg.start_vx);
            default:         prdata = '0;
        endcase
    end

    assign rom_cw  = ucode_rom(r_upc);
    assign in_xfer = i_in_valid && !o_in_stall;
    assign can_out = !r_out_valid || !i_out_stall;

    // conditional jump decision
    always_comb begin
        case (rom_cw.jmp)
            JMP_ALWAYS:   jump_taken = 1'b1;
            JMP_NO_Y_HIT: jump_taken = !dp_status.y_hit;
            JMP_NO_FLOOR: jump_taken = !dp_status.floor_hit;
            JMP_NO_X_HIT: jump_taken = !dp_status.x_hit;
            default:      jump_taken = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: if (in_xfer) n_state = SEQ_RUN;
            SEQ_RUN:  if (rom_cw.done && can_out) n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // sequencer outputs and step counter
    always_comb begin
        o_in_stall = 1'b1;
        dp_cw      = CW_NOP;
        out_load   = 1'b0;
        n_upc      = r_upc;
        unique case (r_state)
            SEQ_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_upc = (i_in_item.op == OP_RESTART) ? UPC_RESTART : UPC_TICK;
                end
            end
            SEQ_RUN: begin
                dp_cw    = rom_cw;
                out_load = rom_cw.done && can_out;
                if (!rom_cw.done) begin
                    n_upc = jump_taken ? rom_cw.target : r_upc + 4'd1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_upc   <= UPC_TICK;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    // step time held for the whole tick
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dt <= i_in_item.dt;
        end
    end

    bbs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cw     (dp_cw),
        .i_cfg    (r_cfg),
        .i_dt     (r_dt),
        .o_status (dp_status),
        .o_result (dp_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
